/* sv/i2p_pkg.sv */
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int Q_DEPTH     = 2;
  localparam int QP_W        = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W        = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_POW    = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_NONE   = 8'h00;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5
  } op_code_t;

  typedef enum logic [1:0] {
    K_OPER,
    K_LPAREN,
    K_RPAREN,
    K_OTHER
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNMATCHED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPER,
    S_LPAREN,
    S_RPAREN,
    S_OTHER,
    S_END
  } back_state_t;

  typedef struct packed {
    kind_t      kind;
    op_code_t   opc;
    logic [7:0] ch;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       expr_done;
    status_t    status;
  } res_t;

  function automatic logic [1:0] op_prec(input op_code_t code);
    logic [1:0] p;
    case (code)
      OP_ADD:  p = 2'd1;
      OP_SUB:  p = 2'd1;
      OP_MUL:  p = 2'd2;
      OP_DIV:  p = 2'd2;
      OP_POW:  p = 2'd3;
      default: p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] c;
    case (code)
      OP_OPEN: c = CH_LPAREN;
      OP_ADD:  c = CH_ADD;
      OP_SUB:  c = CH_SUB;
      OP_MUL:  c = CH_MUL;
      OP_DIV:  c = CH_DIV;
      OP_POW:  c = CH_POW;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

/* sv/i2p_front.sv */
module i2p_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_char,
  input  logic          in_expr_last,
  input  logic          q_full,
  output logic          q_push,
  output i2p_pkg::cmd_t q_cmd
);
  import i2p_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd      = '0;
    q_cmd.ch   = in_char;
    q_cmd.last = in_expr_last;
    case (in_char)
      CH_ADD: begin
        q_cmd.kind = K_OPER;
        q_cmd.opc  = OP_ADD;
      end
      CH_SUB: begin
        q_cmd.kind = K_OPER;
        q_cmd.opc  = OP_SUB;
      end
      CH_MUL: begin
        q_cmd.kind = K_OPER;
        q_cmd.opc  = OP_MUL;
      end
      CH_DIV: begin
        q_cmd.kind = K_OPER;
        q_cmd.opc  = OP_DIV;
      end
      CH_POW: begin
        q_cmd.kind = K_OPER;
        q_cmd.opc  = OP_POW;
      end
      CH_LPAREN: begin
        q_cmd.kind = K_LPAREN;
        q_cmd.opc  = OP_OPEN;
      end
      CH_RPAREN: begin
        q_cmd.kind = K_RPAREN;
        q_cmd.opc  = OP_OPEN;
      end
      default: begin
        q_cmd.kind = K_OTHER;
        q_cmd.opc  = OP_OPEN;
      end
    endcase
  end

endmodule

/* sv/i2p_queue.sv */
module i2p_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  i2p_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output i2p_pkg::cmd_t pop_cmd
);
  import i2p_pkg::*;

  cmd_t            mem_r [Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == QC_W'(Q_DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_cmd = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* sv/i2p_back.sv */
module i2p_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  i2p_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic          out_run_last,
  output logic          out_expr_done,
  output logic [1:0]    out_status
);
  import i2p_pkg::*;

  back_state_t      state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             last_r, last_nxt;
  logic [SP_W-1:0]  sp_r, sp_nxt;
  op_code_t         stack_r [STACK_DEPTH];
  res_t             pend_r, pend_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  res_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [SP_W-1:0]  sp_m1;
  op_code_t         top_code;
  logic             has_ops, stack_full;
  logic             out_room, emit_room;
  logic             emit_en, flush_en, direct_en, push_en;
  res_t             emit_res;
  op_code_t         push_code;
  logic             fin_flush, fin_direct, fin_done;

  // entry zero is the implicit open mark and is never written
  assign sp_m1      = sp_r - 1'b1;
  assign top_code   = (sp_r <= SP_W'(1)) ? OP_OPEN : stack_r[sp_m1[IDX_W-1:0]];
  assign has_ops    = (sp_r > SP_W'(1));
  assign stack_full = (sp_r == SP_W'(STACK_DEPTH));

  assign out_room  = !out_valid_r || !out_stall;
  assign emit_room = !pend_valid_r || out_room;

  // the last word of an item waits in pend until the item is known to be done
  assign fin_flush  = pend_valid_r && out_room;
  assign fin_direct = !pend_valid_r && last_r && out_room;
  assign fin_done   = pend_valid_r ? out_room : (!last_r || out_room);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    last_nxt  = last_r;
    sp_nxt    = sp_r;
    q_pop     = 1'b0;
    emit_en   = 1'b0;
    emit_res  = '0;
    flush_en  = 1'b0;
    direct_en = 1'b0;
    push_en   = 1'b0;
    push_code = OP_OPEN;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_cmd;
          last_nxt = q_cmd.last;
          case (q_cmd.kind)
            K_OPER:   state_nxt = S_OPER;
            K_LPAREN: state_nxt = S_LPAREN;
            K_RPAREN: state_nxt = S_RPAREN;
            default:  state_nxt = S_OTHER;
          endcase
        end
      end
      S_OPER: begin
        if (has_ops && (op_prec(top_code) >= op_prec(cmd_r.opc))) begin
          if (emit_room) begin
            emit_en     = 1'b1;
            emit_res.ch = op_char(top_code);
            sp_nxt      = sp_m1;
          end
        end else if (stack_full) begin
          if (emit_room) begin
            emit_en            = 1'b1;
            emit_res.expr_done = 1'b1;
            emit_res.status    = ST_OVERFLOW;
            sp_nxt             = SP_W'(1);
            last_nxt           = 1'b0;
            state_nxt          = S_END;
          end
        end else begin
          push_en   = 1'b1;
          push_code = cmd_r.opc;
          sp_nxt    = sp_r + 1'b1;
          state_nxt = S_END;
        end
      end
      S_LPAREN: begin
        if (stack_full) begin
          if (emit_room) begin
            emit_en            = 1'b1;
            emit_res.expr_done = 1'b1;
            emit_res.status    = ST_OVERFLOW;
            sp_nxt             = SP_W'(1);
            last_nxt           = 1'b0;
            state_nxt          = S_END;
          end
        end else begin
          push_en   = 1'b1;
          push_code = OP_OPEN;
          sp_nxt    = sp_r + 1'b1;
          state_nxt = S_END;
        end
      end
      S_RPAREN: begin
        if (has_ops && (top_code != OP_OPEN)) begin
          if (emit_room) begin
            emit_en     = 1'b1;
            emit_res.ch = op_char(top_code);
            sp_nxt      = sp_m1;
          end
        end else if (has_ops) begin
          // drop the matching open mark
          sp_nxt    = sp_m1;
          state_nxt = S_END;
        end else if (emit_room) begin
          emit_en            = 1'b1;
          emit_res.expr_done = 1'b1;
          emit_res.status    = ST_UNMATCHED;
          sp_nxt             = SP_W'(1);
          last_nxt           = 1'b0;
          state_nxt          = S_END;
        end
      end
      S_OTHER: begin
        if (emit_room) begin
          emit_en     = 1'b1;
          emit_res.ch = cmd_r.ch;
          state_nxt   = S_END;
        end
      end
      S_END: begin
        if (last_r && (top_code != OP_OPEN)) begin
          if (emit_room) begin
            emit_en     = 1'b1;
            emit_res.ch = op_char(top_code);
            sp_nxt      = sp_m1;
          end
        end else begin
          if (last_r) begin
            sp_nxt = SP_W'(1);
          end
          flush_en  = fin_flush;
          direct_en = fin_direct;
          if (fin_done) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    if (emit_en) begin
      if (pend_valid_r) begin
        out_nxt       = pend_r;
        out_valid_nxt = 1'b1;
      end
      pend_nxt       = emit_res;
      pend_valid_nxt = 1'b1;
    end else if (flush_en) begin
      out_nxt           = pend_r;
      out_nxt.run_last  = 1'b1;
      out_nxt.expr_done = pend_r.expr_done || last_r;
      out_valid_nxt     = 1'b1;
      pend_valid_nxt    = 1'b0;
    end else if (direct_en) begin
      out_nxt           = '0;
      out_nxt.ch        = CH_NONE;
      out_nxt.run_last  = 1'b1;
      out_nxt.expr_done = 1'b1;
      out_nxt.status    = ST_OK;
      out_valid_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      sp_r         <= SP_W'(1);
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sp_r         <= sp_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    last_r <= last_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
    if (push_en) begin
      stack_r[sp_r[IDX_W-1:0]] <= push_code;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_r.ch;
  assign out_run_last  = out_r.run_last;
  assign out_expr_done = out_r.expr_done;
  assign out_status    = out_r.status;

endmodule

/* sv/infix_to_postfix_converter_unit.sv */
// Channel  Valid      Stall       Fields
// input    in_valid   in_stall    in_char[7:0], in_expr_last
// output   out_valid  out_stall   out_char[7:0], out_run_last, out_expr_done, out_status[1:0]
//
// A character is dispatched from the queue, its result words are emitted, a push or the
// drop of a matched open mark follows, and a closing step ends it. The status-only
// word that ends an expression whose last character gives no word is registered
// for output in the closing step.
// The back sequencer moves one operator per cycle through its single stack read while its output has room.
// A two-word queue lets the input side run ahead of the stack sequencer.
// Reset (rst_n low, synchronous) empties the queue and leaves the open mark alone
// on the stack.
// A stalled output holds its word; the sequencer waits while its held word has
// nowhere to go.
module infix_to_postfix_converter_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_expr_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       out_expr_done,
  output logic [1:0] out_status
);
  import i2p_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  cmd_t push_cmd, pop_cmd;

  i2p_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char      (in_char),
    .in_expr_last (in_expr_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  i2p_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  i2p_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_cmd         (pop_cmd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_run_last  (out_run_last),
    .out_expr_done (out_expr_done),
    .out_status    (out_status)
  );

  a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("sequencer took a word from an empty queue");

  a_error_word_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      (out_expr_done && out_run_last && (out_char == CH_NONE)))
    else $error("error word is not a final status-only word");

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_expr_done) |-> out_run_last)
    else $error("expression end word does not close its run");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("unused status code on output");

endmodule
